[rtl/core/ggb_pkg.sv]
// ----------------------------------------------------------------------------
// ggb_pkg: shared types and constants of the glyph grid blitter
// Field widths, opcodes, register indexes and the linear address function.
// ----------------------------------------------------------------------------
package ggb_pkg;

   localparam int OP_W        = 3;
   localparam int ROW_W       = 6;
   localparam int COL_W       = 7;
   localparam int OFF_W       = 8;
   localparam int HGT_W       = 7;
   localparam int WID_W       = 8;
   localparam int GLYPH_W     = 8;
   localparam int GRID_ROWS_W = 7;
   localparam int GRID_COLS_W = 8;
   // row (7 bits) times stride (8 bits) plus column (8 bits)
   localparam int LIN_W       = 16;
   localparam int PADDR_W     = 3;
   localparam int PDATA_W     = 32;

   localparam int DEF_MAX_ROWS = 64;
   localparam int DEF_MAX_COLS = 128;

   localparam logic [OP_W-1:0] OP_READ      = 3'd0;
   localparam logic [OP_W-1:0] OP_WRITE     = 3'd1;
   localparam logic [OP_W-1:0] OP_REL_READ  = 3'd2;
   localparam logic [OP_W-1:0] OP_REL_WRITE = 3'd3;
   localparam logic [OP_W-1:0] OP_FILL      = 3'd4;
   localparam logic [OP_W-1:0] OP_COPY      = 3'd5;

   localparam logic REG_GRID_ROWS = 1'b0;
   localparam logic REG_GRID_COLS = 1'b1;

   localparam logic [GLYPH_W-1:0] GLYPH_NUL = 8'h00;
   localparam logic [GLYPH_W-1:0] GLYPH_DOT = 8'h2E;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } ram_ctl_type;

   typedef struct packed {
      logic               valid;
      logic [GLYPH_W-1:0] glyph;
      logic               ok;
   } result_type;

   function automatic logic [LIN_W-1:0] lin_addr(input logic [GRID_ROWS_W-1:0] y,
                                                 input logic [GRID_COLS_W-1:0] stride,
                                                 input logic [GRID_COLS_W-1:0] x);
      lin_addr = LIN_W'(y) * LIN_W'(stride) + LIN_W'(x);
   endfunction

endpackage

[rtl/core/ggb_csr.sv]
// ----------------------------------------------------------------------------
// ggb_csr: grid size registers
// APB-style write and read of the row count and column count, clamped to the
// grid capacity on write.
// ----------------------------------------------------------------------------
module ggb_csr
   import ggb_pkg::*;
#(
   parameter int MAX_ROWS = DEF_MAX_ROWS,
   parameter int MAX_COLS = DEF_MAX_COLS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [PADDR_W-1:0]     paddr,
   input  logic [PDATA_W-1:0]     pwdata,
   output logic [PDATA_W-1:0]     prdata,
   output logic                   pready,
   output logic [GRID_ROWS_W-1:0] grid_rows,
   output logic [GRID_COLS_W-1:0] grid_cols
);

   logic [GRID_ROWS_W-1:0] rows_ff, rows_in;
   logic [GRID_COLS_W-1:0] cols_ff, cols_in;
   logic                   wr_hit;
   logic                   reg_sel;

   assign pready  = 1'b1;
   assign reg_sel = paddr[2];
   assign wr_hit  = psel && penable && pwrite && pready;

   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      if (wr_hit) begin
         unique case (reg_sel)
            REG_GRID_ROWS: begin
               if (int'(pwdata[GRID_ROWS_W-1:0]) > MAX_ROWS) begin
                  rows_in = GRID_ROWS_W'(MAX_ROWS);
               end else begin
                  rows_in = pwdata[GRID_ROWS_W-1:0];
               end
            end
            REG_GRID_COLS: begin
               if (int'(pwdata[GRID_COLS_W-1:0]) > MAX_COLS) begin
                  cols_in = GRID_COLS_W'(MAX_COLS);
               end else begin
                  cols_in = pwdata[GRID_COLS_W-1:0];
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= '0;
         cols_ff <= '0;
      end else begin
         rows_ff <= rows_in;
         cols_ff <= cols_in;
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_GRID_ROWS: prdata = PDATA_W'(rows_ff);
         REG_GRID_COLS: prdata = PDATA_W'(cols_ff);
         default:       prdata = '0;
      endcase
   end

   assign grid_rows = rows_ff;
   assign grid_cols = cols_ff;

endmodule

[rtl/core/ggb_cell_ram.sv]
// ----------------------------------------------------------------------------
// ggb_cell_ram: cell store
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ggb_cell_ram
   import ggb_pkg::*;
#(
   parameter int DEPTH  = DEF_MAX_ROWS * DEF_MAX_COLS,
   parameter int ADDR_W = 13
) (
   input  logic               clock,
   input  ram_ctl_type        ctl,
   input  logic [ADDR_W-1:0]  rd_addr,
   input  logic [ADDR_W-1:0]  wr_addr,
   input  logic [GLYPH_W-1:0] wr_data,
   output logic [GLYPH_W-1:0] rd_data
);

   logic [GLYPH_W-1:0] mem [DEPTH];
   logic [GLYPH_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/ggb_engine.sv]
// ----------------------------------------------------------------------------
// ggb_engine: access sequencer
// Decodes one word, does single-cell reads and writes, and walks fill and copy
// rectangles through the cell store one cell per cycle.
// ----------------------------------------------------------------------------
module ggb_engine
   import ggb_pkg::*;
#(
   parameter int ADDR_W = 13
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [OP_W-1:0]         req_opcode,
   input  logic [ROW_W-1:0]        req_row,
   input  logic [COL_W-1:0]        req_col,
   input  logic signed [OFF_W-1:0] req_row_offset,
   input  logic signed [OFF_W-1:0] req_col_offset,
   input  logic [HGT_W-1:0]        req_rect_height,
   input  logic [WID_W-1:0]        req_rect_width,
   input  logic [ROW_W-1:0]        req_dest_row,
   input  logic [COL_W-1:0]        req_dest_col,
   input  logic [GLYPH_W-1:0]      req_glyph,
   input  logic [GRID_ROWS_W-1:0]  grid_rows,
   input  logic [GRID_COLS_W-1:0]  grid_cols,
   output ram_ctl_type             ram_ctl,
   output logic [ADDR_W-1:0]       ram_rd_addr,
   output logic [ADDR_W-1:0]       ram_wr_addr,
   output logic [GLYPH_W-1:0]      ram_wr_data,
   input  logic [GLYPH_W-1:0]      ram_rd_data,
   input  logic                    slot_free,
   output result_type              fin
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_READ  = 3'd1;
   localparam logic [2:0] S_SETUP = 3'd2;
   localparam logic [2:0] S_RUN   = 3'd3;
   localparam logic [2:0] S_DRAIN = 3'd4;
   localparam logic [2:0] S_POST  = 3'd5;

   logic [2:0]             state_ff, state_in;
   logic                   pend_valid_ff, pend_valid_in;
   logic [ADDR_W-1:0]      pend_addr_ff, pend_addr_in;

   logic                   copy_ff;
   logic                   row_rev_ff, col_rev_ff;
   logic [HGT_W-1:0]       nr_ff;
   logic [WID_W-1:0]       nc_ff;
   logic [GLYPH_W-1:0]     glyph_ff, glyph_in;
   logic [ROW_W-1:0]       row_ff, drow_ff;
   logic [COL_W-1:0]       col_ff, dcol_ff;
   logic [HGT_W-1:0]       i_ff, i_in;
   logic [WID_W-1:0]       j_ff, j_in;
   logic [ADDR_W-1:0]      src_base_ff, src_base_in;
   logic [ADDR_W-1:0]      dst_base_ff, dst_base_in;
   logic [GLYPH_W-1:0]     res_glyph_ff;
   logic                   res_ok_ff;

   logic                   accept;
   logic                   row_ok, col_ok, drow_ok, dcol_ok;
   logic                   abs_ok, rel_ok;
   logic [9:0]             rel_y, rel_x;
   logic [ADDR_W-1:0]      abs_addr, rel_addr;
   logic [GRID_ROWS_W-1:0] rows_left_src, rows_left_dst;
   logic [GRID_COLS_W-1:0] cols_left_src, cols_left_dst;
   logic [HGT_W-1:0]       fill_nr, copy_nr, acc_nr;
   logic [WID_W-1:0]       fill_nc, copy_nc, acc_nc;
   logic                   acc_copy;

   logic [HGT_W-1:0]       row_span;
   logic [GRID_ROWS_W-1:0] src_y, dst_y;
   logic [GRID_COLS_W-1:0] dst_x;
   logic [WID_W-1:0]       col_pos;
   logic [ADDR_W-1:0]      cur_src, cur_dst, stride;
   logic                   row_end, last_cell;

   logic                   done;
   logic [GLYPH_W-1:0]     done_glyph;
   logic                   done_ok;

   assign accept    = req_valid && (state_ff == S_IDLE);
   assign req_stall = (state_ff != S_IDLE);

   // bounds of the single-cell and anchor accesses
   assign row_ok  = {1'b0, req_row} < grid_rows;
   assign col_ok  = {1'b0, req_col} < grid_cols;
   assign drow_ok = {1'b0, req_dest_row} < grid_rows;
   assign dcol_ok = {1'b0, req_dest_col} < grid_cols;
   assign abs_ok  = row_ok && col_ok;

   assign rel_y  = {4'b0000, req_row} + {{2{req_row_offset[OFF_W-1]}}, req_row_offset};
   assign rel_x  = {3'b000, req_col} + {{2{req_col_offset[OFF_W-1]}}, req_col_offset};
   assign rel_ok = !rel_y[9] && (rel_y[8:0] < {2'b00, grid_rows}) &&
                   !rel_x[9] && (rel_x[8:0] < {1'b0, grid_cols});

   assign abs_addr = ADDR_W'(lin_addr({1'b0, req_row}, grid_cols, {1'b0, req_col}));
   assign rel_addr = ADDR_W'(lin_addr(rel_y[GRID_ROWS_W-1:0], grid_cols,
                                      rel_x[GRID_COLS_W-1:0]));

   // clip rectangle size to the grid edge
   assign rows_left_src = grid_rows - {1'b0, req_row};
   assign rows_left_dst = grid_rows - {1'b0, req_dest_row};
   assign cols_left_src = grid_cols - {1'b0, req_col};
   assign cols_left_dst = grid_cols - {1'b0, req_dest_col};

   always_comb begin
      logic [GRID_ROWS_W-1:0] rmin;
      logic [GRID_COLS_W-1:0] cmin;
      rmin    = (rows_left_src < rows_left_dst) ? rows_left_src : rows_left_dst;
      cmin    = (cols_left_src < cols_left_dst) ? cols_left_src : cols_left_dst;
      fill_nr = (req_rect_height < rows_left_src) ? req_rect_height : rows_left_src;
      fill_nc = (req_rect_width < cols_left_src) ? req_rect_width : cols_left_src;
      copy_nr = (req_rect_height < rmin) ? req_rect_height : rmin;
      copy_nc = (req_rect_width < cmin) ? req_rect_width : cmin;
   end

   assign acc_copy = (req_opcode == OP_COPY);
   assign acc_nr   = acc_copy ? copy_nr : fill_nr;
   assign acc_nc   = acc_copy ? copy_nc : fill_nc;

   // walker addressing
   assign row_span  = row_rev_ff ? (nr_ff - 1'b1) : '0;
   assign src_y     = {1'b0, row_ff} + row_span;
   assign dst_y     = copy_ff ? ({1'b0, drow_ff} + row_span) : {1'b0, row_ff};
   assign dst_x     = copy_ff ? {1'b0, dcol_ff} : {1'b0, col_ff};
   assign col_pos   = col_rev_ff ? (nc_ff - 1'b1 - j_ff) : j_ff;
   assign cur_src   = src_base_ff + ADDR_W'(col_pos);
   assign cur_dst   = dst_base_ff + ADDR_W'(col_pos);
   assign stride    = ADDR_W'(grid_cols);
   assign row_end   = (j_ff == nc_ff - 1'b1);
   assign last_cell = row_end && (i_ff == nr_ff - 1'b1);

   always_comb begin
      state_in      = state_ff;
      pend_valid_in = 1'b0;
      pend_addr_in  = pend_addr_ff;
      glyph_in      = glyph_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      src_base_in   = src_base_ff;
      dst_base_in   = dst_base_ff;
      ram_ctl       = '0;
      ram_rd_addr   = cur_src;
      ram_wr_addr   = cur_dst;
      ram_wr_data   = glyph_ff;
      done          = 1'b0;
      done_glyph    = GLYPH_NUL;
      done_ok       = 1'b0;

      // finish the copy write of the cell read last cycle
      if (pend_valid_ff) begin
         ram_ctl.wr_en = 1'b1;
         ram_wr_addr   = pend_addr_ff;
         ram_wr_data   = ram_rd_data;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               glyph_in = req_glyph;
               i_in     = '0;
               j_in     = '0;
               unique case (req_opcode)
                  OP_READ: begin
                     if (abs_ok) begin
                        ram_ctl.rd_en = 1'b1;
                        ram_rd_addr   = abs_addr;
                        state_in      = S_READ;
                     end else begin
                        done = 1'b1;
                     end
                  end
                  OP_WRITE: begin
                     ram_ctl.wr_en = abs_ok;
                     ram_wr_addr   = abs_addr;
                     ram_wr_data   = req_glyph;
                     done          = 1'b1;
                     done_ok       = abs_ok;
                  end
                  OP_REL_READ: begin
                     if (rel_ok) begin
                        ram_ctl.rd_en = 1'b1;
                        ram_rd_addr   = rel_addr;
                        state_in      = S_READ;
                     end else begin
                        done       = 1'b1;
                        done_glyph = GLYPH_DOT;
                     end
                  end
                  OP_REL_WRITE: begin
                     ram_ctl.wr_en = rel_ok;
                     ram_wr_addr   = rel_addr;
                     ram_wr_data   = req_glyph;
                     done          = 1'b1;
                     done_ok       = rel_ok;
                  end
                  OP_FILL, OP_COPY: begin
                     if (!abs_ok || (acc_copy && !(drow_ok && dcol_ok))) begin
                        done = 1'b1;
                     end else if ((acc_nr == '0) || (acc_nc == '0)) begin
                        done    = 1'b1;
                        done_ok = 1'b1;
                     end else begin
                        state_in = S_SETUP;
                     end
                  end
                  default: begin
                     done = 1'b1;
                  end
               endcase
            end
         end
         S_READ: begin
            done       = 1'b1;
            done_glyph = ram_rd_data;
            done_ok    = 1'b1;
         end
         S_SETUP: begin
            src_base_in = ADDR_W'(lin_addr(src_y, grid_cols, {1'b0, col_ff}));
            dst_base_in = ADDR_W'(lin_addr(dst_y, grid_cols, dst_x));
            state_in    = S_RUN;
         end
         S_RUN: begin
            if (copy_ff) begin
               ram_ctl.rd_en = 1'b1;
               pend_valid_in = 1'b1;
               pend_addr_in  = cur_dst;
            end else begin
               ram_ctl.wr_en = 1'b1;
               ram_wr_addr   = cur_dst;
               ram_wr_data   = glyph_ff;
            end
            if (row_end) begin
               j_in = '0;
               i_in = i_ff + 1'b1;
               if (row_rev_ff) begin
                  src_base_in = src_base_ff - stride;
                  dst_base_in = dst_base_ff - stride;
               end else begin
                  src_base_in = src_base_ff + stride;
                  dst_base_in = dst_base_ff + stride;
               end
            end else begin
               j_in = j_ff + 1'b1;
            end
            if (last_cell) begin
               if (copy_ff) begin
                  state_in = S_DRAIN;
               end else begin
                  done    = 1'b1;
                  done_ok = 1'b1;
               end
            end
         end
         S_DRAIN: begin
            done    = 1'b1;
            done_ok = 1'b1;
         end
         S_POST: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // hand the result over, or park it until the output register drains
      if (done) begin
         state_in = slot_free ? S_IDLE : S_POST;
      end
   end

   always_comb begin
      fin = '0;
      if (state_ff == S_POST) begin
         fin.valid = slot_free;
         fin.glyph = res_glyph_ff;
         fin.ok    = res_ok_ff;
      end else begin
         fin.valid = done && slot_free;
         fin.glyph = done_glyph;
         fin.ok    = done_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_addr_ff <= pend_addr_in;
      glyph_ff     <= glyph_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      src_base_ff  <= src_base_in;
      dst_base_ff  <= dst_base_in;
      if (accept) begin
         copy_ff    <= acc_copy;
         nr_ff      <= acc_nr;
         nc_ff      <= acc_nc;
         row_ff     <= req_row;
         col_ff     <= req_col;
         drow_ff    <= req_dest_row;
         dcol_ff    <= req_dest_col;
         // bottom-up when the source starts above the destination
         row_rev_ff <= acc_copy && (req_row < req_dest_row);
         // right-to-left when the destination lies to the right
         col_rev_ff <= acc_copy && (req_dest_col > req_col);
      end
      if (done && !slot_free) begin
         res_glyph_ff <= done_glyph;
         res_ok_ff    <= done_ok;
      end
   end

endmodule

[rtl/core/glyph_grid_blitter.sv]
// ----------------------------------------------------------------------------
// glyph_grid_blitter: byte-cell grid with single-cell access, fill and copy
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/stall    | opcode, coordinates, size, glyph
//   rsp     | out       | rsp_valid/stall    | read_glyph, in_bounds
//   csr     | in/out    | psel/penable/ready | grid_rows (0x0), grid_cols (0x4)
//
// Write and relative write finish in the idle state; read and relative read
// pass the read state in range and finish in idle out of range. Unknown
// opcode, fill or copy with an anchor outside the grid, or an empty clipped
// rectangle: done in idle. Fill: setup and run; copy: setup, run, drain. The
// clipped H x W rectangle passes the single write port one cell per cycle.
// Reset clears the grid size registers and the control state; the cell store
// is not cleared. A stalled result sits in the output register while the next
// word is taken; a second finished result waits inside the engine.
// ----------------------------------------------------------------------------
module glyph_grid_blitter
   import ggb_pkg::*;
#(
   parameter int MAX_ROWS = DEF_MAX_ROWS,
   parameter int MAX_COLS = DEF_MAX_COLS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [OP_W-1:0]         req_opcode,
   input  logic [ROW_W-1:0]        req_row,
   input  logic [COL_W-1:0]        req_col,
   input  logic signed [OFF_W-1:0] req_row_offset,
   input  logic signed [OFF_W-1:0] req_col_offset,
   input  logic [HGT_W-1:0]        req_rect_height,
   input  logic [WID_W-1:0]        req_rect_width,
   input  logic [ROW_W-1:0]        req_dest_row,
   input  logic [COL_W-1:0]        req_dest_col,
   input  logic [GLYPH_W-1:0]      req_glyph,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [GLYPH_W-1:0]      rsp_read_glyph,
   output logic                    rsp_in_bounds,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [PADDR_W-1:0]      paddr,
   input  logic [PDATA_W-1:0]      pwdata,
   output logic [PDATA_W-1:0]      prdata,
   output logic                    pready
);

   localparam int DEPTH  = MAX_ROWS * MAX_COLS;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [GRID_ROWS_W-1:0] grid_rows;
   logic [GRID_COLS_W-1:0] grid_cols;
   ram_ctl_type            ram_ctl;
   logic [ADDR_W-1:0]      ram_rd_addr, ram_wr_addr;
   logic [GLYPH_W-1:0]     ram_wr_data, ram_rd_data;
   result_type             fin;
   logic                   slot_free;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [GLYPH_W-1:0]     rsp_glyph_ff;
   logic                   rsp_ok_ff;

   ggb_csr #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .grid_rows (grid_rows),
      .grid_cols (grid_cols)
   );

   ggb_cell_ram #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .ctl     (ram_ctl),
      .rd_addr (ram_rd_addr),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_data (ram_rd_data)
   );

   ggb_engine #(
      .ADDR_W (ADDR_W)
   ) u_engine (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_row         (req_row),
      .req_col         (req_col),
      .req_row_offset  (req_row_offset),
      .req_col_offset  (req_col_offset),
      .req_rect_height (req_rect_height),
      .req_rect_width  (req_rect_width),
      .req_dest_row    (req_dest_row),
      .req_dest_col    (req_dest_col),
      .req_glyph       (req_glyph),
      .grid_rows       (grid_rows),
      .grid_cols       (grid_cols),
      .ram_ctl         (ram_ctl),
      .ram_rd_addr     (ram_rd_addr),
      .ram_wr_addr     (ram_wr_addr),
      .ram_wr_data     (ram_wr_data),
      .ram_rd_data     (ram_rd_data),
      .slot_free       (slot_free),
      .fin             (fin)
   );

   // output register: free when empty or being taken this cycle
   assign slot_free    = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = fin.valid || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fin.valid) begin
         rsp_glyph_ff <= fin.glyph;
         rsp_ok_ff    <= fin.ok;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_glyph = rsp_glyph_ff;
   assign rsp_in_bounds  = rsp_ok_ff;

endmodule

[rtl/core/ggb_checker.sv]
// ----------------------------------------------------------------------------
// ggb_checker: port-level checks of the glyph grid blitter
// Tracks words in flight and checks result count, stall hold and out-of-range codes.
// ----------------------------------------------------------------------------
module ggb_checker
   import ggb_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [GLYPH_W-1:0] rsp_read_glyph,
   input logic               rsp_in_bounds
);

   logic [1:0] pend_ff, pend_in;
   logic       in_acc, out_acc;

   assign in_acc  = req_valid && !req_stall;
   assign out_acc = rsp_valid && !rsp_stall;

   always_comb begin
      pend_in = pend_ff;
      if (in_acc && !out_acc) begin
         pend_in = pend_ff + 1'b1;
      end else if (out_acc && !in_acc) begin
         pend_in = pend_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   // no result without a word in flight
   a_rsp_has_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (pend_ff != 2'd0))
      else $error("result word without an accepted request word");

   // at most one result parked behind the output register
   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff != 2'd3)
      else $error("more than two words in flight");

   // an out-of-range access reports null or dot
   a_oob_glyph: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_in_bounds) |->
         ((rsp_read_glyph == GLYPH_NUL) || (rsp_read_glyph == GLYPH_DOT)))
      else $error("out-of-range result with a stray glyph");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_read_glyph) && $stable(rsp_in_bounds)))
      else $error("stalled result word changed");

endmodule

bind glyph_grid_blitter ggb_checker u_ggb_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_read_glyph (rsp_read_glyph),
   .rsp_in_bounds  (rsp_in_bounds)
);
